>>> rtl/core/oen_pkg.sv
`timescale 1ns / 1ps
package oen_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int SLOT_W    = 2;
	localparam int RAM_AW    = SLOT_W + COL_W;
	localparam int RAM_DEPTH = 1 << RAM_AW;
	localparam int MAG_W     = 16;
	localparam int ANG_W     = 8;
	localparam int RAM_W     = MAG_W + ANG_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Q8    = 2'd3;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic [128:0][14:0] qsin_tab_t;

	typedef struct packed {
		logic store;
		logic mul;
		logic center;
		logic pos;
		logic tap_rd;
		logic tap_mul;
		logic tap_acc;
		logic cmp;
		logic att1;
		logic att2;
		logic div;
		logic emit;
	} oen_cmd_t;

	typedef struct packed {
		logic pend_zero;
		logic emit_ok;
		logic tap_last;
		logic side_pos;
		logic s_zero;
		logic div_last;
		logic out_free;
	} oen_stat_t;

	// Quarter-wave sine in Q1.14, from an eight-term Taylor series in Q30.
	function automatic qsin_tab_t build_qsin();
		qsin_tab_t          t;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        v;
		logic [63:0]        q;
		logic signed [63:0] acc;
		for (int k = 0; k <= 128; k++) begin
			x    = (PI_Q30 * 64'(k)) >> 8;
			x2   = (x * x) >> 30;
			acc  = signed'(x);
			term = ((x * x2) >> 30) / 6;
			acc  = acc - signed'(term);
			term = ((term * x2) >> 30) / 20;
			acc  = acc + signed'(term);
			term = ((term * x2) >> 30) / 42;
			acc  = acc - signed'(term);
			term = ((term * x2) >> 30) / 72;
			acc  = acc + signed'(term);
			term = ((term * x2) >> 30) / 110;
			acc  = acc - signed'(term);
			term = ((term * x2) >> 30) / 156;
			acc  = acc + signed'(term);
			term = ((term * x2) >> 30) / 210;
			acc  = acc - signed'(term);
			v    = (acc < 0) ? 64'd0 : unsigned'(acc);
			q    = (v + 64'd32768) >> 16;
			if (q > 64'd16384) begin
				q = 64'd16384;
			end
			t[k] = q[14:0];
		end
		return t;
	endfunction

	localparam qsin_tab_t QSIN = build_qsin();

	function automatic logic signed [15:0] cos14(input logic [7:0] k);
		if (k <= 8'd128) begin
			return signed'({1'b0, QSIN[8'd128 - k]});
		end
		return -signed'({1'b0, QSIN[k - 8'd128]});
	endfunction

	function automatic logic signed [15:0] sin14(input logic [7:0] k);
		if (k <= 8'd128) begin
			return signed'({1'b0, QSIN[k]});
		end
		return signed'({1'b0, QSIN[8'd0 - k]});
	endfunction

endpackage

>>> rtl/core/oen_pix_if.sv
`timescale 1ns / 1ps
interface oen_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] magnitude;
	logic [7:0]  angle_code;
	logic        is_flush;
	modport source(output valid, magnitude, angle_code, is_flush, input ready);
	modport sink(input valid, magnitude, angle_code, is_flush, output ready);
endinterface

>>> rtl/core/oen_res_if.sv
`timescale 1ns / 1ps
interface oen_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] suppressed_value;
	logic        last_of_frame;
	modport source(output valid, suppressed_value, last_of_frame, input ready);
	modport sink(input valid, suppressed_value, last_of_frame, output ready);
endinterface

>>> rtl/core/oen_cfg_if.sv
`timescale 1ns / 1ps
interface oen_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/oriented_edge_nms.sv
`timescale 1ns / 1ps
// Oriented edge non-maximum suppression over a raster-order pixel stream. A pixel with no
// result due, or a flush with nothing pending, returns to idle after its check. A pixel with
// a result due is compared and attenuated; a zero border band skips the divider, and the
// emit waits while the previous result still sits in the output register. The eight bilinear
// taps are read one after another from the single-read-port line memory, and the border
// attenuation runs through a one-bit-per-cycle divider. Results trail the input by one row
// and one pixel; flush items drain the rest of a finished frame. The line memory holds four
// rows and needs no clearing after reset. Configuration is taken while the block is idle.
module oriented_edge_nms (
	input  logic       clk,
	input  logic       arst_n,
	oen_pix_if.sink    pixel,
	oen_res_if.source  result,
	oen_cfg_if.sink    cfg
);
	import oen_pkg::*;

	oen_cmd_t  cmd;
	oen_stat_t stat;

	assign cfg.ready = pixel.ready;

	oen_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	oen_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mag_in    (pixel.magnitude),
		.ang_in    (pixel.angle_code),
		.flush_in  (pixel.is_flush),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_value (result.suppressed_value),
		.out_last  (result.last_of_frame)
	);
endmodule

>>> rtl/core/oen_ram.sv
`timescale 1ns / 1ps
module oen_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/core/oen_ctrl.sv
`timescale 1ns / 1ps
module oen_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  oen_pkg::oen_stat_t stat,
	output oen_pkg::oen_cmd_t  cmd
);
	import oen_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_CHECK2, S_CENTER, S_POS, S_TRD, S_TMUL, S_TACC,
		S_CMP, S_ATT1, S_ATT2, S_DIV, S_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.store   = in_valid && in_ready;
		cmd.mul     = (state_q == S_CHECK);
		cmd.center  = (state_q == S_CENTER);
		cmd.pos     = (state_q == S_POS);
		cmd.tap_rd  = (state_q == S_TRD);
		cmd.tap_mul = (state_q == S_TMUL);
		cmd.tap_acc = (state_q == S_TACC);
		cmd.cmp     = (state_q == S_CMP);
		cmd.att1    = (state_q == S_ATT1);
		cmd.att2    = (state_q == S_ATT2);
		cmd.div     = (state_q == S_DIV);
		cmd.emit    = (state_q == S_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_CHECK;
				S_CHECK:  state_q <= stat.pend_zero ? S_IDLE : S_CHECK2;
				S_CHECK2: state_q <= stat.emit_ok ? S_CENTER : S_IDLE;
				S_CENTER: state_q <= S_POS;
				S_POS:    state_q <= S_TRD;
				S_TRD:    state_q <= S_TMUL;
				S_TMUL:   state_q <= S_TACC;
				S_TACC:   state_q <= stat.tap_last ? S_CMP : S_TRD;
				S_CMP:    state_q <= stat.side_pos ? S_ATT1 : S_POS;
				S_ATT1:   state_q <= S_ATT2;
				S_ATT2:   state_q <= stat.s_zero ? S_EMIT : S_DIV;
				S_DIV:    if (stat.div_last) state_q <= S_EMIT;
				S_EMIT:   if (stat.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/oen_dp.sv
`timescale 1ns / 1ps
module oen_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  oen_pkg::oen_cmd_t                cmd,
	output oen_pkg::oen_stat_t               stat,
	input  logic [oen_pkg::MAG_W-1:0]        mag_in,
	input  logic [oen_pkg::ANG_W-1:0]        ang_in,
	input  logic                             flush_in,
	input  logic                             cfg_we,
	input  logic [oen_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [oen_pkg::CFG_DAT_W-1:0]    cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [oen_pkg::MAG_W-1:0]        out_value,
	output logic                             out_last
);
	import oen_pkg::*;

	logic [10:0] fw_q;
	logic [11:0] fh_q;
	logic [4:0]  bw_q;
	logic [8:0]  mg_q;
	logic [10:0] wc;
	logic [11:0] hc;

	logic [COL_W-1:0]  in_col_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [COL_W-1:0]  out_col_q;
	logic [11:0]       out_row_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [11:0]       pending_q;

	logic [22:0] hw_q;
	logic [22:0] rw_q;

	logic                 ram_we;
	logic [RAM_AW-1:0]    ram_waddr;
	logic [RAM_AW-1:0]    ram_raddr;
	logic [RAM_W-1:0]     ram_rdata;

	logic [MAG_W-1:0]   e_q;
	logic signed [15:0] co_q;
	logic signed [15:0] si_q;
	logic               side_q;
	logic               supp_q;
	logic [24:0]        lhs_q;
	logic [COL_W-1:0]   x0_q;
	logic [13:0]        fx_q;
	logic [13:0]        fy_q;
	logic [SLOT_W-1:0]  s0_q;
	logic [1:0]         tap_q;
	logic [28:0]        wgt_q;
	logic [44:0]        prod_q;
	logic [45:0]        acc_q;

	logic [4:0]  s_q;
	logic [4:0]  b_q;
	logic [15:0] v_q;
	logic [20:0] va_q;
	logic [9:0]  den_q;
	logic [9:0]  rem_q;
	logic [15:0] dvd_q;
	logic [3:0]  cnt_q;

	logic               out_valid_q;
	logic [MAG_W-1:0]   out_value_q;
	logic               out_last_q;

	logic signed [15:0] dx;
	logic signed [15:0] dy;
	logic signed [28:0] px;
	logic signed [28:0] py;
	logic signed [28:0] hix;
	logic signed [28:0] hiy;
	logic signed [28:0] pxc;
	logic signed [28:0] pyc;
	logic [14:0]        wx;
	logic [14:0]        wy;
	logic [SLOT_W-1:0]  tslot;
	logic [COL_W-1:0]   tcol;
	logic [15:0]        vsel;
	logic [4:0]         smin;
	logic [4:0]         da;
	logic [4:0]         db;
	logic [25:0]        num;
	logic [10:0]        trial;
	logic               ge;
	logic [COL_W:0]     in_col_nx;
	logic [COL_W:0]     out_col_nx;
	logic [12:0]        out_row_nx;

	function automatic logic [4:0] edist(input logic [11:0] i, input logic [11:0] size,
	                                     input logic [4:0] s);
		logic [11:0] last;
		logic [11:0] d;
		last = size - 12'd1;
		d    = (i <= last) ? ((i < last - i) ? i : last - i) : 12'd0;
		return (d < 12'(s)) ? d[4:0] : s;
	endfunction

	assign wc = (fw_q < 11'd2) ? 11'd2 :
	            (fw_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : fw_q;
	assign hc = (fh_q < 12'd2) ? 12'd2 : fh_q;

	assign ram_we    = cmd.store && !flush_in;
	assign ram_waddr = {in_slot_q, in_col_q};
	assign tslot     = tap_q[1] ? s0_q + 2'd1 : s0_q;
	assign tcol      = x0_q + COL_W'(tap_q[0]);
	assign ram_raddr = cmd.tap_rd ? {tslot, tcol} : {out_slot_q, out_col_q};

	oen_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({ang_in, mag_in}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		dx  = side_q ? co_q : -co_q;
		dy  = side_q ? si_q : -si_q;
		px  = signed'({5'd0, out_col_q, 14'd0}) + 29'(dx);
		py  = signed'({3'd0, out_row_q, 14'd0}) + 29'(dy);
		hix = signed'({4'd0, wc - 11'd1, 14'd0}) - 29'sd16;
		hiy = signed'({3'd0, hc - 12'd1, 14'd0}) - 29'sd16;
		pxc = (px < 0) ? 29'sd0 : ((px > hix) ? hix : px);
		pyc = (py < 0) ? 29'sd0 : ((py > hiy) ? hiy : py);
		wx  = tap_q[0] ? {1'b0, fx_q} : 15'd16384 - {1'b0, fx_q};
		wy  = tap_q[1] ? {1'b0, fy_q} : 15'd16384 - {1'b0, fy_q};
		vsel = supp_q ? 16'd0 : e_q;
		smin = bw_q;
		if (10'(smin) > wc[10:1]) smin = wc[5:1];
		if (11'(smin) > hc[11:1]) smin = hc[5:1];
		da    = edist(12'(out_col_q), 12'(wc), smin);
		db    = edist(out_row_q, hc, smin);
		num   = va_q * b_q;
		trial = {rem_q, dvd_q[15]};
		ge    = trial >= {1'b0, den_q};
		in_col_nx  = {1'b0, in_col_q} + 1'b1;
		out_col_nx = {1'b0, out_col_q} + 1'b1;
		out_row_nx = {1'b0, out_row_q} + 1'b1;
	end

	assign stat.pend_zero = (pending_q == 12'd0);
	assign stat.emit_ok   = (pending_q >= 12'(wc) + 12'd2) ||
	                        (24'(pending_q) + 24'(rw_q) + 24'(out_col_q) >= 24'(hw_q));
	assign stat.tap_last  = (tap_q == 2'd3);
	assign stat.side_pos  = side_q;
	assign stat.s_zero    = (s_q == 5'd0);
	assign stat.div_last  = (cnt_q == 4'd15);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q        <= 11'd640;
			fh_q        <= 12'd480;
			bw_q        <= 5'd5;
			mg_q        <= 9'd259;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  fw_q <= cfg_data[10:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_data;
					REG_BORDER_WIDTH: bw_q <= cfg_data[4:0];
					REG_MARGIN_Q8:    mg_q <= cfg_data[8:0];
					default:          ;
				endcase
			end
			if (cmd.store && !flush_in) begin
				pending_q <= pending_q + 12'd1;
				if (in_col_nx >= wc) begin
					in_col_q  <= '0;
					in_slot_q <= in_slot_q + 2'd1;
				end else begin
					in_col_q <= in_col_nx[COL_W-1:0];
				end
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				pending_q   <= pending_q - 12'd1;
				if (out_col_nx >= wc) begin
					out_col_q  <= '0;
					out_slot_q <= out_slot_q + 2'd1;
					out_row_q  <= (out_row_nx >= 13'(hc)) ? 12'd0 : out_row_nx[11:0];
				end else begin
					out_col_q <= out_col_nx[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			hw_q <= hc * wc;
			rw_q <= out_row_q * wc;
		end
		if (cmd.center) begin
			e_q    <= ram_rdata[MAG_W-1:0];
			co_q   <= cos14(ram_rdata[RAM_W-1:MAG_W]);
			si_q   <= sin14(ram_rdata[RAM_W-1:MAG_W]);
			side_q <= 1'b0;
			supp_q <= 1'b0;
		end
		if (cmd.pos) begin
			x0_q  <= pxc[23:14];
			fx_q  <= pxc[13:0];
			fy_q  <= pyc[13:0];
			s0_q  <= out_slot_q + pyc[15:14] - out_row_q[1:0];
			lhs_q <= e_q * mg_q;
			acc_q <= '0;
			tap_q <= '0;
		end
		if (cmd.tap_rd) begin
			wgt_q <= 29'(wx * wy);
		end
		if (cmd.tap_mul) begin
			// A tap of zero weight adds nothing, whatever its entry holds.
			prod_q <= (wgt_q == 29'd0) ? 45'd0 : ram_rdata[MAG_W-1:0] * wgt_q;
		end
		if (cmd.tap_acc) begin
			acc_q <= acc_q + 46'(prod_q);
			tap_q <= tap_q + 2'd1;
		end
		if (cmd.cmp) begin
			if (46'({lhs_q, 20'd0}) < acc_q) begin
				supp_q <= 1'b1;
			end
			side_q <= 1'b1;
		end
		if (cmd.att1) begin
			s_q  <= smin;
			b_q  <= db;
			v_q  <= vsel;
			va_q <= vsel * da;
		end
		if (cmd.att2) begin
			den_q <= s_q * s_q;
			rem_q <= num[25:16];
			dvd_q <= (s_q == 5'd0) ? v_q : num[15:0];
			cnt_q <= '0;
		end
		if (cmd.div) begin
			rem_q <= ge ? 10'(trial - {1'b0, den_q}) : trial[9:0];
			dvd_q <= {dvd_q[14:0], ge};
			cnt_q <= cnt_q + 4'd1;
		end
		if (cmd.emit) begin
			out_value_q <= dvd_q;
			out_last_q  <= (out_row_q >= hc - 12'd1) && (11'(out_col_q) >= wc - 11'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
endmodule
